FILE: rtl/core/rlsm_pkg.sv
// ----------------------------------------------------------------------------
// rlsm_pkg
// Shared constants and the exp fraction table generator for the activation unit.
// ----------------------------------------------------------------------------
package rlsm_pkg;

  localparam int COLUMN_DEPTH_DEF   = 16;
  localparam int EXP_TABLE_SIZE_DEF = 64;

  localparam logic [1:0] MODE_RELU    = 2'd0;
  localparam logic [1:0] MODE_LEAKY   = 2'd1;
  localparam logic [1:0] MODE_SOFTMAX = 2'd2;

  localparam logic [0:0] CFG_MODE  = 1'b0;
  localparam logic [0:0] CFG_SLOPE = 1'b1;

  localparam logic [15:0] SLOPE_RESET = 16'd655;
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  // floor(a / b) by shift and subtract, table build only
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned rem;
    longint unsigned q;
    rem = 64'd0;
    q   = 64'd0;
    for (int j = 63; j >= 0; j--) begin
      rem = (rem << 1) | ((a >> j) & 64'd1);
      q   = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // 2^-x series in Q30, x already scaled, result in Q16
  function automatic logic [16:0] exp_entry(input longint unsigned x);
    longint unsigned sum;
    longint unsigned term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int i = 1; i <= 24; i++) begin
      term = udiv64((term * x) >> 30, longint'(i));
      if (i[0]) sum = sum - term;
      else sum = sum + term;
    end
    return 17'((sum + 64'd8192) >> 14);
  endfunction

endpackage

FILE: rtl/core/relu_leaky_softmax_activation_unit.sv
// ----------------------------------------------------------------------------
// relu_leaky_softmax_activation_unit
// ReLU, leaky ReLU and column softmax on signed Q8.8 elements.
// ----------------------------------------------------------------------------
// Input transactions carry in_sample and in_end_of_column; output transactions
// carry out_activation, out_final_res and out_overflow. cfg_we writes mode
// (index 0) or leak_slope (index 1); the user must write them only while the
// unit is idle, which the unit itself does not enforce.
// ReLU modes: one result per input, registered, in the cycle after acceptance;
// one transaction per cycle when the receiver keeps out_ready high.
// Softmax: each element is written to the column RAM with no result. The
// end-marked element starts an exp pass over the stored elements (RAM read,
// log2(e) multiply, table lookup and accumulate), a reciprocal, then an output
// pass per element (RAM read, multiply, output register).
// Elements past COLUMN_DEPTH are dropped and flag out_overflow.
// Reset restores mode and slope defaults and clears count, running max and
// overflow; no RAM clear.
// A stalled receiver holds the output register and halts the sequencer.
// ----------------------------------------------------------------------------
module relu_leaky_softmax_activation_unit #(
  parameter int COLUMN_DEPTH   = rlsm_pkg::COLUMN_DEPTH_DEF,
  parameter int EXP_TABLE_SIZE = rlsm_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               in_end_of_column,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_activation,
  output logic               out_final_res,
  output logic               out_overflow,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int AW = $clog2(COLUMN_DEPTH);
  localparam int CW = $clog2(COLUMN_DEPTH + 1);
  localparam int IW = $clog2(EXP_TABLE_SIZE);
  localparam int SW = 17 + AW;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_EXP, S_DIV, S_ORD, S_OMUL, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0]  mode_r;
  logic [15:0] slope_r;
  logic [CW-1:0] count_r;
  logic signed [15:0] max_r;
  logic ovf_r;
  logic [AW-1:0] idx_r;
  logic [32:0] p_r;
  logic [SW-1:0] sum_r;
  logic [16:0] recip_r;
  logic [33:0] prod_r;
  logic div_start_r;
  logic out_valid_r;
  logic signed [16:0] out_act_r;
  logic out_final_r;
  logic out_ovf_r;

  logic [16:0] exp_tbl [EXP_TABLE_SIZE];
  for (genvar k = 0; k < EXP_TABLE_SIZE; k++) begin : g_tbl
    localparam longint unsigned XK =
      (longint'(k) * rlsm_pkg::LN2_Q30) / longint'(EXP_TABLE_SIZE);
    localparam logic [16:0] EK = rlsm_pkg::exp_entry(XK);
    assign exp_tbl[k] = EK;
  end

  logic in_acc;
  logic out_free;
  logic col_we;
  logic [15:0] col_rdata;
  logic [16:0] e_rdata;
  logic signed [16:0] diff;
  logic [32:0] fi;
  logic [IW-1:0] tidx;
  logic [16:0] e_val;
  logic [16:0] leaky_mag;
  logic [32:0] leaky_prod;
  logic [16:0] leaky_q;
  logic div_done;
  logic [16:0] quot;
  logic [CW-1:0] count_inc;
  logic last_idx;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign col_we    = in_acc && (mode_r == rlsm_pkg::MODE_SOFTMAX) &&
                     (count_r < CW'(COLUMN_DEPTH));
  assign count_inc = count_r + CW'(1);
  assign last_idx  = (CW'(idx_r) == count_r - CW'(1));

  assign diff = 17'(max_r) - 17'($signed(col_rdata));
  assign fi   = {9'd0, p_r[23:0]} * 33'(EXP_TABLE_SIZE);
  assign tidx = fi[24 +: IW];
  assign e_val = (p_r[32:24] >= 9'd17) ? 17'd0 : (exp_tbl[tidx] >> p_r[28:24]);

  assign leaky_mag  = 17'd0 - 17'(in_sample);
  assign leaky_prod = {16'd0, leaky_mag} * {17'd0, slope_r};
  assign leaky_q    = 17'((leaky_prod + 33'd65535) >> 16);

  rlsm_ram #(.WIDTH(16), .DEPTH(COLUMN_DEPTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_sample),
    .raddr (idx_r),
    .rdata (col_rdata)
  );

  rlsm_ram #(.WIDTH(17), .DEPTH(COLUMN_DEPTH)) u_exp_ram (
    .clk   (clk),
    .we    (state_r == S_EXP),
    .waddr (idx_r),
    .wdata (e_val),
    .raddr (idx_r),
    .rdata (e_rdata)
  );

  rlsm_div #(.SW(SW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .divisor (sum_r),
    .done    (div_done),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= rlsm_pkg::MODE_RELU;
      slope_r     <= rlsm_pkg::SLOPE_RESET;
      count_r     <= '0;
      max_r       <= 16'sh8000;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rlsm_pkg::CFG_MODE:  mode_r  <= cfg_wdata[1:0];
          rlsm_pkg::CFG_SLOPE: slope_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (mode_r != rlsm_pkg::MODE_SOFTMAX) begin
              out_valid_r <= 1'b1;
              out_final_r <= 1'b0;
              out_ovf_r   <= 1'b0;
              if (in_sample > 16'sd0) out_act_r <= 17'(in_sample);
              else if (mode_r == rlsm_pkg::MODE_LEAKY) out_act_r <= 17'd0 - leaky_q;
              else out_act_r <= '0;
            end else begin
              if (col_we) begin
                count_r <= count_inc;
                if (in_sample > max_r) max_r <= in_sample;
              end else begin
                ovf_r <= 1'b1;
              end
              if (in_end_of_column) begin
                idx_r   <= '0;
                sum_r   <= '0;
                state_r <= S_RD;
              end
            end
          end
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: begin
          p_r     <= {17'd0, diff[15:0]} * {16'd0, rlsm_pkg::LOG2E_Q16};
          state_r <= S_EXP;
        end
        S_EXP: begin
          sum_r <= sum_r + SW'(e_val);
          if (last_idx) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            recip_r <= quot;
            idx_r   <= '0;
            state_r <= S_ORD;
          end
        end
        S_ORD: state_r <= S_OMUL;
        S_OMUL: begin
          prod_r  <= {17'd0, e_rdata} * {17'd0, recip_r};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_final_r <= last_idx;
            out_ovf_r   <= ovf_r;
            if (prod_r[33:16] == 18'd0) out_act_r <= 17'd1;
            else if (prod_r[33:32] != 2'd0) out_act_r <= 17'd65535;
            else out_act_r <= {1'b0, prod_r[31:16]};
            if (last_idx) begin
              count_r <= '0;
              max_r   <= 16'sh8000;
              ovf_r   <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_activation = out_act_r;
  assign out_final_res  = out_final_r;
  assign out_overflow   = out_ovf_r;

endmodule

FILE: rtl/core/rlsm_ram.sv
// ----------------------------------------------------------------------------
// rlsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rlsm_div.sv
// ----------------------------------------------------------------------------
// rlsm_div
// Restoring divider computing floor(2^32 / divisor), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlsm_div #(
  parameter int SW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [16:0]   quot
);

  logic [SW-1:0] rem_r;
  logic [16:0]   quot_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [SW:0]   shifted;
  logic          ge;

  assign shifted = {rem_r, (cnt_r == 6'd0)};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? SW'(shifted - {1'b0, divisor}) : shifted[SW-1:0];
        quot_r <= {quot_r[15:0], ge};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relu_leaky_softmax_activation_unit testbench
// Drives ReLU, leaky ReLU and column softmax traffic with random idling and
// back-pressure, predicts every output transaction and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int STORE_DEPTH = rlsm_pkg::COLUMN_DEPTH_DEF;
  localparam int FRAC_ENTRIES = rlsm_pkg::EXP_TABLE_SIZE_DEF;
  localparam int DRAIN_CYCLES = 6 * STORE_DEPTH + 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_LEN = 300;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } element_t;

  typedef struct packed {
    logic [16:0] act;
    logic        fin;
    logic        ovf;
  } activation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic in_end_of_column = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [16:0] out_activation;
  logic out_final_res;
  logic out_overflow;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  element_t pending_elements[$];
  activation_t expected_activations[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_taken = 1'b0;
  int hold_off_cycles = 0;
  int errors = 0;
  int cycles = 0;

  // predictor state
  logic [1:0] cur_mode = rlsm_pkg::MODE_RELU;
  logic [15:0] cur_slope = rlsm_pkg::SLOPE_RESET;
  logic signed [15:0] col_store[STORE_DEPTH];
  int col_count = 0;
  logic signed [15:0] col_max = -16'sd32768;
  logic col_dropped = 1'b0;
  logic [16:0] frac_table[FRAC_ENTRIES];

  relu_leaky_softmax_activation_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** relu_leaky_softmax_activation_unit: FAILED **");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (pending_elements.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_sample <= pending_elements[0].sample;
        in_end_of_column <= pending_elements[0].last;
        pending_elements.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      hold_off_cycles <= HOLD_OFF_LEN;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [16:0] frac_entry(int k);
    longint unsigned x, acc, term;
    x = (longint'(k) * 64'd744261118) / FRAC_ENTRIES;
    acc = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * x) >> 30) / i;
      acc = (i % 2 == 1) ? acc - term : acc + term;
    end
    return 17'((acc + 64'd8192) >> 14);
  endfunction

  function automatic logic [16:0] exp_neg(logic [15:0] m);
    longint unsigned p, n, idx;
    p = longint'(m) * 64'd94548;
    n = p >> 24;
    idx = ((p & 64'hFFFFFF) * FRAC_ENTRIES) >> 24;
    if (n >= 17) return '0;
    return frac_table[idx] >> n;
  endfunction

  task automatic predict_activation(logic signed [15:0] x, logic last);
    activation_t r;
    longint unsigned e[STORE_DEPTH];
    longint unsigned total, recip, prob, q;
    if (cur_mode != rlsm_pkg::MODE_SOFTMAX) begin
      r = '0;
      if (x > 0) r.act = 17'(x);
      else if (cur_mode == rlsm_pkg::MODE_LEAKY) begin
        q = (longint'(-int'(x)) * cur_slope + 65535) >> 16;
        r.act = 17'(-longint'(q));
      end
      expected_activations.push_back(r);
      return;
    end
    if (col_count < STORE_DEPTH) begin
      col_store[col_count] = x;
      col_count++;
      if (x > col_max) col_max = x;
    end else col_dropped = 1'b1;
    if (!last) return;
    total = 0;
    for (int i = 0; i < col_count; i++) begin
      e[i] = exp_neg(16'(col_max - col_store[i]));
      total += e[i];
    end
    recip = (64'd1 << 32) / total;
    for (int i = 0; i < col_count; i++) begin
      prob = (e[i] * recip) >> 16;
      if (prob < 1) prob = 1;
      if (prob > 65535) prob = 65535;
      r.act = 17'(prob);
      r.fin = (i + 1 == col_count);
      r.ovf = col_dropped;
      expected_activations.push_back(r);
    end
    col_count = 0;
    col_max = -16'sd32768;
    col_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready) predict_activation(in_sample, in_end_of_column);
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_activations.size() == 0) begin
        $error("unexpected transaction: activation %0h", out_activation);
        errors++;
      end else begin
        if (out_activation !== expected_activations[0].act) begin
          $error("activation: expected %0h, actual %0h",
                 expected_activations[0].act, out_activation);
          errors++;
        end
        if (out_final_res !== expected_activations[0].fin) begin
          $error("final_res: expected %0b, actual %0b",
                 expected_activations[0].fin, out_final_res);
          errors++;
        end
        if (out_overflow !== expected_activations[0].ovf) begin
          $error("overflow: expected %0b, actual %0b",
                 expected_activations[0].ovf, out_overflow);
          errors++;
        end
        expected_activations.pop_front();
      end
    end
  end

  task automatic wait_idle();
    while (pending_elements.size() > 0 || in_valid || expected_activations.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == rlsm_pkg::CFG_MODE) cur_mode = value[1:0];
    else cur_slope = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_element(logic signed [15:0] x, logic last);
    pending_elements.push_back('{sample: x, last: last});
  endtask

  task automatic push_column(int len, bit narrow);
    logic signed [15:0] x;
    for (int i = 0; i < len; i++) begin
      x = narrow ? 16'($signed($urandom_range(2047)) - 1024) : 16'($urandom);
      push_element(x, i == len - 1);
    end
  endtask

  task automatic random_block(int budget);
    int used, len;
    used = 0;
    while (used < budget) begin
      write_reg(rlsm_pkg::CFG_MODE, 16'($urandom_range(3)));
      if ($urandom_range(1)) write_reg(rlsm_pkg::CFG_SLOPE, 16'($urandom));
      if (cur_mode == rlsm_pkg::MODE_SOFTMAX) begin
        repeat ($urandom_range(4, 2)) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1)
                                         : $urandom_range(STORE_DEPTH, 1);
          push_column(len, $urandom_range(1));
          used += len;
        end
      end else begin
        repeat (20) begin
          push_element(16'($urandom), $urandom_range(1));
          used++;
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < FRAC_ENTRIES; k++) frac_table[k] = frac_entry(k);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    push_element(16'sh7FFF, 1'b0); push_element(-16'sh8000, 1'b1);
    push_element(16'sh0000, 1'b0); push_element(-16'sh0001, 1'b0);
    write_reg(rlsm_pkg::CFG_MODE, {14'd0, rlsm_pkg::MODE_LEAKY});
    push_element(-16'sh8000, 1'b0); push_element(-16'sh0001, 1'b0);
    push_element(16'sh0001, 1'b0);
    write_reg(rlsm_pkg::CFG_SLOPE, 16'hFFFF);
    push_element(-16'sh8000, 1'b0); push_element(-16'sh0100, 1'b1);
    write_reg(rlsm_pkg::CFG_SLOPE, 16'h0000);
    push_element(-16'sh8000, 1'b0); push_element(-16'sh0001, 1'b0);
    write_reg(rlsm_pkg::CFG_MODE, {14'd0, MODE_RESERVED});
    push_element(-16'sh1234, 1'b0); push_element(16'sh1234, 1'b0);
    write_reg(rlsm_pkg::CFG_MODE, {14'd0, rlsm_pkg::MODE_SOFTMAX});
    push_element(16'sh0100, 1'b1);
    push_element(16'sh7FFF, 1'b0); push_element(-16'sh8000, 1'b0);
    push_element(16'sh7FFF, 1'b1);
    push_column(STORE_DEPTH + 2, 1'b1);
    // mode change with a partly loaded column
    push_element(16'sh0200, 1'b0); push_element(-16'sh0080, 1'b0);
    write_reg(rlsm_pkg::CFG_MODE, {14'd0, rlsm_pkg::MODE_RELU});
    push_element(-16'sh0300, 1'b1); push_element(16'sh0300, 1'b1);
    write_reg(rlsm_pkg::CFG_MODE, {14'd0, rlsm_pkg::MODE_SOFTMAX});
    push_element(16'sh0000, 1'b1);

    // long receiver hold-off while the sender keeps offering
    write_reg(rlsm_pkg::CFG_MODE, {14'd0, rlsm_pkg::MODE_LEAKY});
    hold_off_req = 1'b1;
    repeat (30) push_element(16'($urandom), 1'b0);
    random_block(50);

    send_idle_pct = 45;
    random_block(80);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    random_block(80);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    random_block(80);

    wait_idle();
    if (errors == 0) begin
      $display("** relu_leaky_softmax_activation_unit: PASSED **");
    end else begin
      $display("** relu_leaky_softmax_activation_unit: FAILED **");
    end
    $finish;
  end

endmodule
